/* design/cfa_pkg.sv */
// Package for the contiguous frame allocator: codes, frame-state encodings,
// controller/datapath command and status types. No dependencies.
`default_nettype none
package cfa_pkg;

    localparam int DEF_MAX_FRAMES = 16384;
    // wide enough for any frame count or offset up to 2^20
    localparam int XW = 21;
    // pool_frames reset value
    localparam int CFG_FRAMES_RST = 16384;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_MARK    = 2'd2;
    localparam logic [1:0] OP_INIT    = 2'd3;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_NO_ROOM = 2'd1;
    localparam logic [1:0] STS_NO_HEAD = 2'd2;
    localparam logic [1:0] STS_BAD     = 2'd3;

    localparam logic [1:0] CFG_POOL_BASE   = 2'd0;
    localparam logic [1:0] CFG_POOL_FRAMES = 2'd1;
    localparam logic [1:0] CFG_RESERVE     = 2'd2;

    // per-frame state, four frames to a memory row, frame 0 in bits [1:0]
    localparam logic [1:0] FS_HEAD   = 2'd0;
    localparam logic [1:0] FS_FOLLOW = 2'd1;
    localparam logic [1:0] FS_FREE   = 2'd3;
    localparam logic [7:0] ROW_FREE  = 8'hFF;
    localparam logic [7:0] ROW_RSV   = 8'hFC;

    typedef enum logic [2:0] {
        C_NONE, C_LOAD, C_CHECK, C_CLEAR, C_SCAN, C_MARK, C_REL
    } t_cmd;

    typedef enum logic [2:0] {
        P_FAIL, P_SCAN, P_MARK, P_REL, P_INIT
    } t_path;

    typedef struct packed {
        t_path path;
        logic  last;
        logic  found;
    } t_dp_sts;

endpackage
`default_nettype wire

/* design/cfa_datapath.sv */
// Datapath of the frame allocator: config registers, frame-state memory,
// counters and result registers. Depends on cfa_pkg.
`default_nettype none
module cfa_datapath
    import cfa_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_dp_sts          o_sts,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [19:0] i_cfg_wdata,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [19:0] i_frame_number,
    input  wire logic [14:0] i_count,
    output logic [1:0]       o_status,
    output logic [19:0]      o_result_frame,
    output logic [14:0]      o_free_left
);

    localparam int ROWS = MAX_FRAMES / 4;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int FW   = RW + 2;
    localparam int CW   = $clog2(MAX_FRAMES + 1);
    localparam logic [XW-1:0] MAXV     = XW'(MAX_FRAMES);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam int RST_FREE = ((CFG_FRAMES_RST > MAX_FRAMES) ? MAX_FRAMES
                              : CFG_FRAMES_RST) / 4 * 4;

    logic [7:0] mem [ROWS];
    logic [7:0] r_q;

    logic [19:0]   r_base;
    logic [14:0]   r_pframes;
    logic          r_rsv_cfg;
    logic [1:0]    r_op;
    logic [19:0]   r_fno;
    logic [14:0]   r_cnt;
    logic [CW-1:0] r_n, n_n;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_run, n_run;
    logic [FW-1:0] r_start, n_start;
    logic [FW:0]   r_end, n_end;
    logic [1:0]    r_status, n_status;
    logic [19:0]   r_res, n_res;
    logic [CW-1:0] r_free, n_free;
    logic          r_init_rsv, n_init_rsv;
    logic          mem_we;
    logic [7:0]    wdata;

    always_comb begin
        logic [XW-1:0] nx, off, run, st, f, acc, nrows;
        logic          range_bad, fnd, stop, rsv;
        n_n = r_n; n_row = r_row; n_run = r_run; n_start = r_start; n_end = r_end;
        n_status = r_status; n_res = r_res; n_free = r_free; n_init_rsv = r_init_rsv;
        mem_we = 1'b0; wdata = r_q;
        o_sts.path = P_FAIL; o_sts.last = 1'b0; o_sts.found = 1'b0;
        nx = XW'(r_pframes);
        if (nx > MAXV) nx = MAXV;
        nx = nx & ~XW'(3);
        off = XW'(r_fno) - XW'(r_base);
        range_bad = (r_fno < r_base) || (off >= XW'(r_n));
        nrows = XW'(r_n) >> 2;
        run = XW'(r_run); st = '0; f = '0; acc = '0;
        fnd = 1'b0; stop = 1'b0; rsv = 1'b0;
        case (i_cmd)
            C_LOAD: begin
                n_n = CW'(nx);
            end
            C_CHECK: begin
                n_status = STS_OK;
                n_res = '0;
                n_start = FW'(off);
                n_row = RW'(off >> 2);
                n_end = (FW+1)'(off + XW'(r_cnt));
                n_run = '0;
                case (r_op)
                    OP_ALLOC: begin
                        if (r_cnt == '0) n_status = STS_BAD;
                        else if (XW'(r_cnt) > XW'(r_free) || r_n == '0)
                            n_status = STS_NO_ROOM;
                        else begin
                            o_sts.path = P_SCAN;
                            n_row = '0;
                        end
                    end
                    OP_RELEASE: begin
                        if (range_bad) n_status = STS_BAD;
                        else o_sts.path = P_REL;
                    end
                    OP_MARK: begin
                        if (r_cnt == '0 || range_bad || XW'(r_cnt) > XW'(r_n) - off)
                            n_status = STS_BAD;
                        else o_sts.path = P_MARK;
                    end
                    default: begin
                        rsv = r_rsv_cfg && (r_n != '0);
                        o_sts.path = P_INIT;
                        n_init_rsv = rsv;
                        n_free = r_n - CW'(rsv);
                        n_row = LAST_ROW;
                    end
                endcase
            end
            C_CLEAR: begin
                mem_we = 1'b1;
                wdata = (r_row == '0 && r_init_rsv) ? ROW_RSV : ROW_FREE;
                o_sts.last = (r_row == '0);
                if (r_row != '0) n_row = r_row - 1'b1;
            end
            C_SCAN: begin
                for (int j = 0; j < 4; j++) begin
                    if (!fnd) begin
                        if (r_q[2*j +: 2] == FS_FREE) run = run + 1'b1;
                        else run = '0;
                        if (run == XW'(r_cnt)) begin
                            fnd = 1'b1;
                            st = XW'({r_row, 2'(j)}) + 1'b1 - XW'(r_cnt);
                        end
                    end
                end
                n_run = CW'(run);
                if (fnd) begin
                    o_sts.found = 1'b1;
                    n_start = FW'(st);
                    n_end = (FW+1)'(st + XW'(r_cnt));
                    n_row = RW'(st >> 2);
                end else if (XW'(r_row) + 1'b1 == nrows) begin
                    o_sts.last = 1'b1;
                    n_status = STS_NO_ROOM;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            C_MARK: begin
                for (int j = 0; j < 4; j++) begin
                    f = XW'({r_row, 2'(j)});
                    if (f >= XW'(r_start) && f < XW'(r_end)) begin
                        if (r_q[2*j +: 2] == FS_FREE) acc = acc + 1'b1;
                        wdata[2*j +: 2] = (f == XW'(r_start)) ? FS_HEAD : FS_FOLLOW;
                    end
                end
                mem_we = 1'b1;
                n_free = (acc > XW'(r_free)) ? '0 : CW'(XW'(r_free) - acc);
                if (((XW'(r_row) + 1'b1) << 2) >= XW'(r_end)) begin
                    o_sts.last = 1'b1;
                    n_status = STS_OK;
                    n_res = (r_op == OP_ALLOC) ? 20'(XW'(r_base) + XW'(r_start)) : r_fno;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            C_REL: begin
                if (r_row == r_start[FW-1:2] &&
                    r_q[{r_start[1:0], 1'b0} +: 2] != FS_HEAD) begin
                    o_sts.last = 1'b1;
                    n_status = STS_NO_HEAD;
                end else begin
                    for (int j = 0; j < 4; j++) begin
                        f = XW'({r_row, 2'(j)});
                        if (f >= XW'(r_start) && !stop) begin
                            if (f == XW'(r_start) || r_q[2*j +: 2] == FS_FOLLOW) begin
                                wdata[2*j +: 2] = FS_FREE;
                                acc = acc + 1'b1;
                            end else begin
                                stop = 1'b1;
                            end
                        end
                    end
                    mem_we = 1'b1;
                    acc = XW'(r_free) + acc;
                    n_free = (acc > MAXV) ? CW'(MAXV) : CW'(acc);
                    if (stop || XW'(r_row) + 1'b1 == nrows) begin
                        o_sts.last = 1'b1;
                        n_status = STS_OK;
                        n_res = r_fno;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // frame-state memory: one write and one registered read per cycle at r_row
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[r_row] <= wdata;
        r_q <= mem[r_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_pframes  <= 15'(CFG_FRAMES_RST);
            r_rsv_cfg  <= 1'b1;
            r_row      <= LAST_ROW;
            r_free     <= CW'(RST_FREE);
            r_init_rsv <= 1'b0;
            r_status   <= STS_OK;
            r_res      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POOL_BASE:   r_base    <= i_cfg_wdata;
                    CFG_POOL_FRAMES: r_pframes <= i_cfg_wdata[14:0];
                    CFG_RESERVE:     r_rsv_cfg <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            r_row      <= n_row;
            r_free     <= n_free;
            r_init_rsv <= n_init_rsv;
            r_status   <= n_status;
            r_res      <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == C_LOAD) begin
            r_op  <= i_opcode;
            r_fno <= i_frame_number;
            r_cnt <= i_count;
        end
        r_n     <= n_n;
        r_run   <= n_run;
        r_start <= n_start;
        r_end   <= n_end;
    end

    assign o_status       = r_status;
    assign o_result_frame = r_res;
    assign o_free_left    = 15'(r_free);

endmodule
`default_nettype wire

/* design/cfa_ctrl.sv */
// Controller of the frame allocator: sequences clear, scan, mark and release
// passes through the datapath. Depends on cfa_pkg.
`default_nettype none
module cfa_ctrl
    import cfa_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_dp_sts i_sts,
    output t_cmd         o_cmd,
    output logic         o_busy,
    output logic         o_done
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_EV,
        S_MARK_RD, S_MARK_WR, S_REL_RD, S_REL_WR
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;
    logic   r_from_cmd, n_from_cmd;

    always_comb begin
        n_state = r_state;
        n_done = 1'b0;
        n_from_cmd = r_from_cmd;
        o_cmd = C_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd = C_LOAD;
                    n_state = S_CHECK;
                end
            end
            S_CLEAR: begin
                o_cmd = C_CLEAR;
                if (i_sts.last) begin
                    n_state = S_IDLE;
                    n_done = r_from_cmd;
                end
            end
            S_CHECK: begin
                o_cmd = C_CHECK;
                case (i_sts.path)
                    P_SCAN: n_state = S_SCAN_RD;
                    P_MARK: n_state = S_MARK_RD;
                    P_REL:  n_state = S_REL_RD;
                    P_INIT: begin
                        n_state = S_CLEAR;
                        n_from_cmd = 1'b1;
                    end
                    default: begin
                        n_state = S_IDLE;
                        n_done = 1'b1;
                    end
                endcase
            end
            S_SCAN_RD: n_state = S_SCAN_EV;
            S_SCAN_EV: begin
                o_cmd = C_SCAN;
                if (i_sts.found) n_state = S_MARK_RD;
                else if (i_sts.last) begin
                    n_state = S_IDLE;
                    n_done = 1'b1;
                end else n_state = S_SCAN_RD;
            end
            S_MARK_RD: n_state = S_MARK_WR;
            S_MARK_WR: begin
                o_cmd = C_MARK;
                if (i_sts.last) begin
                    n_state = S_IDLE;
                    n_done = 1'b1;
                end else n_state = S_MARK_RD;
            end
            S_REL_RD: n_state = S_REL_WR;
            S_REL_WR: begin
                o_cmd = C_REL;
                if (i_sts.last) begin
                    n_state = S_IDLE;
                    n_done = 1'b1;
                end else n_state = S_REL_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_done     <= 1'b0;
            r_from_cmd <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_done     <= n_done;
            r_from_cmd <= n_from_cmd;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule
`default_nettype wire

/* design/contiguous_frame_allocator.sv */
// Top level of the contiguous frame allocator: controller plus datapath.
// Depends on cfa_pkg, cfa_ctrl, cfa_datapath.
`default_nettype none
// Frame pool manager with a two-bit state per frame (free, head, follower),
// stored four frames to a row in a MAX_FRAMES/4-row memory. Issue an item by
// raising start while busy is low; exactly one result follows, shown for one
// cycle with o_done high, and must be taken then: there is no hold-off.
// The memory walk reads each row, then evaluates or writes it: allocate
// checks, scans rows up to the fit, then marks the rows of the run; release
// and mark used check, then touch the rows of the run; initialise writes
// every row. After reset the same sweep clears the memory (MAX_FRAMES/4
// rows, 4096 by default) with busy high; config writes are taken during it.
// Write config only when idle.
module contiguous_frame_allocator
    import cfa_pkg::*;
#(
    parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [19:0] i_cfg_wdata,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [19:0] i_frame_number,
    input  wire logic [14:0] i_count,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [19:0]      o_result_frame,
    output logic [14:0]      o_free_left
);

    t_cmd    cmd;
    t_dp_sts sts;

    // sequencer: one state per memory access phase
    cfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // memory, free count, range checks; results held until the next item
    cfa_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_opcode       (i_opcode),
        .i_frame_number (i_frame_number),
        .i_count        (i_count),
        .o_status       (o_status),
        .o_result_frame (o_result_frame),
        .o_free_left    (o_free_left)
    );

endmodule
`default_nettype wire

/* design/cfa_checker.sv */
// Port-level checks for the frame allocator, bound to the top level.
// Depends on cfa_pkg and the contiguous_frame_allocator ports.
`default_nettype none
module cfa_checker
    import cfa_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_done,
    input wire logic [1:0]  o_status,
    input wire logic [19:0] o_result_frame
);

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted item not in work");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != STS_OK) |-> (o_result_frame == 20'd0))
        else $error("failure with nonzero frame");

    a_one_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than a cycle");

endmodule

bind contiguous_frame_allocator cfa_checker u_cfa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_status       (o_status),
    .o_result_frame (o_result_frame)
);
`default_nettype wire
